@@ hw/rtl/rsrg_pkg.sv @@
// Shared types, sizes and the entry ordering for the replacement-selection run generator.
// Used by every other file in hw/rtl. It has no dependencies of its own.
`timescale 1ns / 1ps

package rsrg_pkg;

  // Workspace size and field widths.
  localparam int SLOTS     = 8;
  localparam int KEY_BITS  = 16;
  localparam int RUN_BITS  = 16;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_BITS = $clog2(SLOTS + 1);

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_idx_t;
  typedef logic [FILL_BITS-1:0] fill_t;
  typedef logic [RUN_BITS-1:0]  run_t;
  typedef logic [SLOTS-1:0]     slot_vec_t;

  // One workspace entry as seen on the scan read port.
  typedef struct packed {
    logic valid;
    logic next_run;
    key_t key;
  } entry_t;

  // Result of a winner scan. Done pulses for one cycle when the fields are final.
  typedef struct packed {
    logic      done;
    slot_idx_t idx;
    logic      next_run;
    key_t      key;
  } winner_t;

  // One result beat offered to the output stage.
  typedef struct packed {
    logic valid;
    key_t key;
    run_t run_index;
    logic run_end;
    logic last;
  } beat_t;

  // Entries of the current run come first, then the lower key wins.
  function automatic logic entry_less(input logic a_next, input key_t a_key,
                                      input logic b_next, input key_t b_key);
    logic res;
    if (a_next != b_next) begin
      res = !a_next;
    end else begin
      res = (a_key < b_key);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/rsrg_scan.sv @@
// Winner scan: walks the workspace one slot per cycle through a single shared comparator.
// Depends on rsrg_pkg for the entry and winner types and the ordering function.
`timescale 1ns / 1ps

module rsrg_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rsrg_pkg::entry_t   rd_entry,
  output rsrg_pkg::slot_idx_t rd_idx,
  output rsrg_pkg::winner_t  winner
);

  localparam rsrg_pkg::slot_idx_t LAST_IDX = rsrg_pkg::slot_idx_t'(rsrg_pkg::SLOTS - 1);

  logic                busy;
  logic                done;
  logic                have_best;
  rsrg_pkg::slot_idx_t idx;
  rsrg_pkg::slot_idx_t best_idx;
  logic                best_next;
  rsrg_pkg::key_t      best_key;
  logic                take;

  // The candidate replaces the current best if it is valid and orders lower.
  // Strict ordering keeps the lowest slot among equal entries.
  assign take = rd_entry.valid &&
                (!have_best || rsrg_pkg::entry_less(rd_entry.next_run, rd_entry.key,
                                                    best_next, best_key));

  assign rd_idx = idx;

  // Scan control: one slot per cycle, done pulses after the last slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      have_best <= 1'b0;
      idx       <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        have_best <= 1'b0;
        idx       <= '0;
      end else if (busy) begin
        if (take) begin
          have_best <= 1'b1;
        end
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Best-so-far payload.
  always_ff @(posedge clk) begin
    if (busy && !start && take) begin
      best_idx  <= idx;
      best_next <= rd_entry.next_run;
      best_key  <= rd_entry.key;
    end
  end

  assign winner.done     = done;
  assign winner.idx      = best_idx;
  assign winner.next_run = best_next;
  assign winner.key      = best_key;

  // A scan raises done once it has examined the last slot.
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    busy && !start && (idx == LAST_IDX) |=> done)
    else $error("scan did not finish after the last slot");

  // Done is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("scan done held longer than one cycle");

  // While scanning, the best index never runs ahead of the walk.
  a_best_behind: assert property (@(posedge clk) disable iff (rst)
    busy && have_best |-> best_idx < idx || best_idx == idx)
    else $error("best slot ahead of scan position");

endmodule

@@ hw/rtl/rsrg_out.sv @@
// Output register: holds one result beat so the sequencer can run while the receiver stalls.
// Depends on rsrg_pkg for the beat type and field widths.
`timescale 1ns / 1ps

module rsrg_out (
  input  logic                clk,
  input  logic                rst,
  input  rsrg_pkg::beat_t     beat,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output rsrg_pkg::key_t      out_key,
  output rsrg_pkg::run_t      run_index,
  output logic                run_end,
  output logic                last
);

  // The register can take a new beat when empty or when its beat leaves this cycle.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= beat.valid;
    end
  end

  // Payload loads only with a new beat.
  always_ff @(posedge clk) begin
    if (free && beat.valid) begin
      out_key   <= beat.key;
      run_index <= beat.run_index;
      run_end   <= beat.run_end;
      last      <= beat.last;
    end
  end

endmodule

@@ hw/rtl/replacement_selection_run_generator_unit.sv @@
// Replacement-selection run generator for external merge sort: workspace, sequencer, top level.
// Depends on rsrg_pkg, rsrg_scan and rsrg_out.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) takes one beat per item: a key, or end_of_input.
// The output channel (out_valid/out_ready) carries result beats: emitted keys and run-end
// markers, with last set on the final beat that an item causes.
// The first SLOTS keys fill the workspace and produce no beat.
// Each later key is accepted, then a winner scan walks the workspace one slot per cycle
// through one shared comparator, then the winning key is emitted; a run-end beat follows
// when the run ends.
// end_of_input flushes the workspace: each emitted key takes a full scan and then its emit,
// with a run-end beat where the run changes and one at the end. The block then returns
// to its reset state; an empty workspace gives no beats.
// in_ready is high only while the sequencer is idle, so one item is worked at a time.
// A one-beat output register decouples the receiver; when it stalls, the sequencer waits
// at its next emit and the workspace holds.
// Reset (rst, synchronous) empties the workspace and sets the run number to one.
module replacement_selection_run_generator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsrg_pkg::key_t      in_key,
  input  logic                end_of_input,
  output logic                out_valid,
  input  logic                out_ready,
  output rsrg_pkg::key_t      out_key,
  output rsrg_pkg::run_t      run_index,
  output logic                run_end,
  output logic                last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NSCAN = 3'd1;
  localparam logic [2:0] ST_NEMIT = 3'd2;
  localparam logic [2:0] ST_NREND = 3'd3;
  localparam logic [2:0] ST_FSCAN = 3'd4;
  localparam logic [2:0] ST_FREND = 3'd5;
  localparam logic [2:0] ST_FEMIT = 3'd6;
  localparam logic [2:0] ST_FEND  = 3'd7;

  localparam rsrg_pkg::fill_t FILL_FULL = rsrg_pkg::fill_t'(rsrg_pkg::SLOTS);
  localparam rsrg_pkg::run_t  RUN_FIRST = rsrg_pkg::run_t'(1);

  logic [2:0]          state;
  logic [2:0]          state_next;

  rsrg_pkg::key_t      slot_key [rsrg_pkg::SLOTS];
  rsrg_pkg::slot_vec_t slot_valid;
  rsrg_pkg::slot_vec_t slot_next_run;
  rsrg_pkg::fill_t     fill_count;
  rsrg_pkg::run_t      run_counter;
  rsrg_pkg::key_t      hold_key;

  rsrg_pkg::slot_idx_t rd_idx;
  rsrg_pkg::entry_t    rd_entry;
  rsrg_pkg::winner_t   winner;
  rsrg_pkg::beat_t     beat;
  logic                out_free;

  rsrg_pkg::slot_vec_t win_onehot;
  logic                new_next;
  logic                run_done;
  logic                scan_start;
  logic                hold_load;
  logic                wr_en;
  rsrg_pkg::slot_idx_t wr_idx;
  rsrg_pkg::key_t      wr_key;
  logic                wr_next;
  logic                fill_inc;
  logic                clr_valid;
  logic                adv_run;
  logic                reset_all;

  assign in_ready = (state == ST_IDLE);

  // Scan read port.
  assign rd_entry.valid    = slot_valid[rd_idx];
  assign rd_entry.next_run = slot_next_run[rd_idx];
  assign rd_entry.key      = slot_key[rd_idx];

  rsrg_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .rd_entry (rd_entry),
    .rd_idx   (rd_idx),
    .winner   (winner)
  );

  // Replacement decision: the new key goes to the next run if it is below the emitted key.
  // The run ends when every entry left then belongs to the next run.
  assign win_onehot = rsrg_pkg::slot_vec_t'(1) << winner.idx;
  assign new_next   = (hold_key < winner.key);
  assign run_done   = new_next && (&(slot_next_run | win_onehot));

  // Sequencer.
  always_comb begin
    state_next = state;
    scan_start = 1'b0;
    hold_load  = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = winner.idx;
    wr_key     = hold_key;
    wr_next    = 1'b0;
    fill_inc   = 1'b0;
    clr_valid  = 1'b0;
    adv_run    = 1'b0;
    reset_all  = 1'b0;
    beat.valid     = 1'b0;
    beat.key       = '0;
    beat.run_index = run_counter;
    beat.run_end   = 1'b0;
    beat.last      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (end_of_input) begin
            if (|slot_valid) begin
              scan_start = 1'b1;
              state_next = ST_FSCAN;
            end else begin
              reset_all = 1'b1;
            end
          end else if (fill_count < FILL_FULL) begin
            wr_en    = 1'b1;
            wr_idx   = fill_count[rsrg_pkg::SLOT_BITS-1:0];
            wr_key   = in_key;
            fill_inc = 1'b1;
          end else begin
            hold_load  = 1'b1;
            scan_start = 1'b1;
            state_next = ST_NSCAN;
          end
        end
      end
      ST_NSCAN: begin
        if (winner.done) begin
          state_next = ST_NEMIT;
        end
      end
      ST_NEMIT: begin
        if (out_free) begin
          beat.valid = 1'b1;
          beat.key   = winner.key;
          beat.last  = !run_done;
          wr_en      = 1'b1;
          wr_next    = new_next;
          state_next = run_done ? ST_NREND : ST_IDLE;
        end
      end
      ST_NREND: begin
        if (out_free) begin
          beat.valid   = 1'b1;
          beat.run_end = 1'b1;
          beat.last    = 1'b1;
          adv_run      = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_FSCAN: begin
        if (winner.done) begin
          state_next = winner.next_run ? ST_FREND : ST_FEMIT;
        end
      end
      ST_FREND: begin
        if (out_free) begin
          beat.valid   = 1'b1;
          beat.run_end = 1'b1;
          adv_run      = 1'b1;
          state_next   = ST_FEMIT;
        end
      end
      ST_FEMIT: begin
        if (out_free) begin
          beat.valid = 1'b1;
          beat.key   = winner.key;
          clr_valid  = 1'b1;
          if (|(slot_valid & ~win_onehot)) begin
            scan_start = 1'b1;
            state_next = ST_FSCAN;
          end else begin
            state_next = ST_FEND;
          end
        end
      end
      ST_FEND: begin
        if (out_free) begin
          beat.valid   = 1'b1;
          beat.run_end = 1'b1;
          beat.last    = 1'b1;
          reset_all    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Workspace tags, fill count and run number.
  always_ff @(posedge clk) begin
    if (rst || reset_all) begin
      slot_valid    <= '0;
      slot_next_run <= '0;
      fill_count    <= '0;
      run_counter   <= RUN_FIRST;
    end else begin
      if (wr_en) begin
        slot_valid[wr_idx]    <= 1'b1;
        slot_next_run[wr_idx] <= wr_next;
      end
      if (clr_valid) begin
        slot_valid[winner.idx] <= 1'b0;
      end
      if (adv_run) begin
        slot_next_run <= '0;
        run_counter   <= run_counter + 1'b1;
      end
      if (fill_inc) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Workspace keys and the held input key.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_key[wr_idx] <= wr_key;
    end
    if (hold_load) begin
      hold_key <= in_key;
    end
  end

  rsrg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_key   (out_key),
    .run_index (run_index),
    .run_end   (run_end),
    .last      (last)
  );

  // The fill count never passes the workspace size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_FULL)
    else $error("fill count beyond workspace size");

  // A full workspace outside a flush has every slot occupied.
  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_NSCAN || state == ST_NEMIT) &&
    (fill_count == FILL_FULL) |-> (&slot_valid))
    else $error("full workspace has an empty slot");

  // A scan result only arrives while the sequencer waits for one.
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    winner.done |-> (state == ST_NSCAN || state == ST_FSCAN))
    else $error("scan finished outside a scan state");

  // The flush only emits an occupied slot.
  a_flush_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEMIT) |-> slot_valid[winner.idx])
    else $error("flush emits an empty slot");

  // A run-end beat carries a zero key.
  a_run_end_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_end |-> (out_key == '0))
    else $error("run-end beat with nonzero key");

endmodule
